// File: rtl/core/glcm_pkg.sv
// ----------------------------------------------------------------------------
// glcm_pkg
// Shared types, codes and default sizes for the horizontal GLCM builder.
// ----------------------------------------------------------------------------
package glcm_pkg;

    // Default sizes handed to the top-level parameters
    localparam int unsigned LEVELS_DEF     = 256;
    localparam int unsigned COUNT_BITS_DEF = 32;

    // Fixed field widths
    localparam int unsigned KIND_W    = 2;
    localparam int unsigned GRAY_W    = 8;
    localparam int unsigned OUT_W     = 32;
    localparam int unsigned FRAC_W    = 17;
    localparam int unsigned FRAC_BITS = 16;
    localparam int unsigned DIV_CNT_W = $clog2(FRAC_BITS);

    // Item kinds
    localparam logic [KIND_W-1:0] KIND_PIXEL = 2'd0;
    localparam logic [KIND_W-1:0] KIND_READ  = 2'd1;
    localparam logic [KIND_W-1:0] KIND_CLEAR = 2'd2;

    // Fraction value for an entry that equals the total
    localparam logic [FRAC_W-1:0] FRAC_ONE = 17'h10000;

    typedef enum logic [3:0] {
        S_CLEAR,
        S_IDLE,
        S_DISPATCH,
        S_PIX_WA,
        S_PIX_WB,
        S_RD_WAIT,
        S_DIV_SETUP,
        S_DIV_STEP,
        S_OUT
    } t_state;

    // Commands from the controller to the datapath
    typedef struct packed {
        logic load;        // capture the accepted item
        logic rd_a;        // read entry at address A
        logic rd_b;        // read entry at address B
        logic wr_a;        // write incremented entry A
        logic wr_b;        // write incremented entry B
        logic tot_inc;     // add two to the pair total
        logic take_entry;  // capture the read entry
        logic div_init;    // start the fraction division
        logic div_step;    // one restoring division step
        logic out_load;    // load the output register
        logic clr_start;   // zero total, restart the sweep counter
        logic sweep;       // write zero at the sweep address
    } t_cmd;

    // Status from the datapath to the controller
    typedef struct packed {
        logic [KIND_W-1:0] kind;
        logic              ok;          // pair or read entry within range
        logic              same;        // both levels of the pair are equal
        logic              sweep_last;
        logic              div_short;   // fraction known without iteration
        logic              div_last;
        logic              out_free;
    } t_stat;

endpackage

// File: rtl/core/glcm_ctrl.sv
// ----------------------------------------------------------------------------
// glcm_ctrl
// Sequencer for the GLCM builder: sweep, pixel updates, reads and division.
// ----------------------------------------------------------------------------
module glcm_ctrl (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_valid,
    output logic            o_stall,
    input  glcm_pkg::t_stat i_stat,
    output glcm_pkg::t_cmd  o_cmd
);

    glcm_pkg::t_state r_state;
    glcm_pkg::t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= glcm_pkg::S_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

    // Next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            glcm_pkg::S_CLEAR: begin
                if (i_stat.sweep_last) n_state = glcm_pkg::S_IDLE;
            end
            glcm_pkg::S_IDLE: begin
                if (i_valid) n_state = glcm_pkg::S_DISPATCH;
            end
            glcm_pkg::S_DISPATCH: begin
                case (i_stat.kind)
                    glcm_pkg::KIND_PIXEL: begin
                        n_state = i_stat.ok ? glcm_pkg::S_PIX_WA : glcm_pkg::S_IDLE;
                    end
                    glcm_pkg::KIND_READ:  n_state = glcm_pkg::S_RD_WAIT;
                    glcm_pkg::KIND_CLEAR: n_state = glcm_pkg::S_CLEAR;
                    default:              n_state = glcm_pkg::S_IDLE;
                endcase
            end
            glcm_pkg::S_PIX_WA: begin
                n_state = i_stat.same ? glcm_pkg::S_IDLE : glcm_pkg::S_PIX_WB;
            end
            glcm_pkg::S_PIX_WB:    n_state = glcm_pkg::S_IDLE;
            glcm_pkg::S_RD_WAIT:   n_state = glcm_pkg::S_DIV_SETUP;
            glcm_pkg::S_DIV_SETUP: begin
                n_state = i_stat.div_short ? glcm_pkg::S_OUT : glcm_pkg::S_DIV_STEP;
            end
            glcm_pkg::S_DIV_STEP: begin
                if (i_stat.div_last) n_state = glcm_pkg::S_OUT;
            end
            glcm_pkg::S_OUT: begin
                if (i_stat.out_free) n_state = glcm_pkg::S_IDLE;
            end
            default: n_state = glcm_pkg::S_IDLE;
        endcase
    end

    // Outputs
    always_comb begin
        o_cmd   = '0;
        o_stall = 1'b1;
        case (r_state)
            glcm_pkg::S_CLEAR: o_cmd.sweep = 1'b1;
            glcm_pkg::S_IDLE: begin
                o_stall    = 1'b0;
                o_cmd.load = i_valid;
            end
            glcm_pkg::S_DISPATCH: begin
                case (i_stat.kind)
                    glcm_pkg::KIND_PIXEL: o_cmd.rd_a      = i_stat.ok;
                    glcm_pkg::KIND_READ:  o_cmd.rd_a      = i_stat.ok;
                    glcm_pkg::KIND_CLEAR: o_cmd.clr_start = 1'b1;
                    default:              o_cmd.rd_a      = 1'b0;
                endcase
            end
            glcm_pkg::S_PIX_WA: begin
                o_cmd.wr_a    = 1'b1;
                o_cmd.tot_inc = 1'b1;
                o_cmd.rd_b    = !i_stat.same;
            end
            glcm_pkg::S_PIX_WB:    o_cmd.wr_b       = 1'b1;
            glcm_pkg::S_RD_WAIT:   o_cmd.take_entry = 1'b1;
            glcm_pkg::S_DIV_SETUP: o_cmd.div_init   = 1'b1;
            glcm_pkg::S_DIV_STEP:  o_cmd.div_step   = 1'b1;
            glcm_pkg::S_OUT:       o_cmd.out_load   = i_stat.out_free;
            default:               o_stall          = 1'b1;
        endcase
    end

endmodule

// File: rtl/core/glcm_dpath.sv
// ----------------------------------------------------------------------------
// glcm_dpath
// Item registers, count memory, saturating adders, fraction divider and
// output register of the GLCM builder.
// ----------------------------------------------------------------------------
module glcm_dpath #(
    parameter int unsigned LEVELS     = glcm_pkg::LEVELS_DEF,
    parameter int unsigned COUNT_BITS = glcm_pkg::COUNT_BITS_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  glcm_pkg::t_cmd                i_cmd,
    output glcm_pkg::t_stat               o_stat,
    input  logic [glcm_pkg::KIND_W-1:0]   i_kind,
    input  logic [glcm_pkg::GRAY_W-1:0]   i_gray,
    input  logic                          i_row_first,
    input  logic [glcm_pkg::GRAY_W-1:0]   i_row_level,
    input  logic [glcm_pkg::GRAY_W-1:0]   i_col_level,
    output logic                          o_valid,
    input  logic                          i_stall,
    output logic [glcm_pkg::OUT_W-1:0]    o_entry_count,
    output logic [glcm_pkg::OUT_W-1:0]    o_total_pairs,
    output logic [glcm_pkg::FRAC_W-1:0]   o_fraction
);

    localparam int unsigned DEPTH     = LEVELS * LEVELS;
    localparam int unsigned ADDR_BITS = $clog2(DEPTH);
    localparam int unsigned LVL_BITS  = $clog2(LEVELS);
    localparam int unsigned CMP_W     = ((LVL_BITS + 1) > glcm_pkg::GRAY_W) ?
                                        (LVL_BITS + 1) : glcm_pkg::GRAY_W;

    // Item registers
    logic [glcm_pkg::KIND_W-1:0] r_kind;
    logic [glcm_pkg::GRAY_W-1:0] r_prev;
    logic                        r_ok;
    logic                        r_same;
    logic [ADDR_BITS-1:0]        r_addr_a;
    logic [ADDR_BITS-1:0]        r_addr_b;

    // Count memory
    logic [COUNT_BITS-1:0] mem [DEPTH];
    logic [COUNT_BITS-1:0] r_mem_q;
    logic                  mem_we;
    logic [ADDR_BITS-1:0]  mem_wa;
    logic [COUNT_BITS-1:0] mem_wd;
    logic                  mem_re;
    logic [ADDR_BITS-1:0]  mem_ra;

    logic [ADDR_BITS-1:0]  r_sweep;
    logic [COUNT_BITS-1:0] r_total;
    logic [COUNT_BITS-1:0] r_entry;

    // Divider
    logic [COUNT_BITS-1:0]          r_rem;
    logic [glcm_pkg::FRAC_W-1:0]    r_quo;
    logic [glcm_pkg::DIV_CNT_W-1:0] r_div_cnt;
    logic [COUNT_BITS:0]            rem2;
    logic [COUNT_BITS:0]            rem_diff;

    // Output register
    logic                        r_o_valid;
    logic [glcm_pkg::OUT_W-1:0]  r_o_entry;
    logic [glcm_pkg::OUT_W-1:0]  r_o_total;
    logic [glcm_pkg::FRAC_W-1:0] r_o_frac;

    // Decode of the incoming item
    logic                 cur_in;
    logic                 prev_in;
    logic                 row_in;
    logic                 col_in;
    logic [LVL_BITS-1:0]  lvl_a_hi;
    logic [LVL_BITS-1:0]  lvl_a_lo;
    logic [ADDR_BITS-1:0] addr_a;
    logic [ADDR_BITS-1:0] addr_b;
    logic                 is_pixel;

    // Saturating increments
    logic [COUNT_BITS:0]   sum_a;
    logic [COUNT_BITS:0]   sum_b;
    logic [COUNT_BITS:0]   sum_t;
    logic [COUNT_BITS-1:0] sat_a;
    logic [COUNT_BITS-1:0] sat_b;
    logic [COUNT_BITS-1:0] sat_t;

    always_comb begin
        is_pixel = (i_kind == glcm_pkg::KIND_PIXEL);
        cur_in   = CMP_W'(i_gray) < CMP_W'(LEVELS);
        prev_in  = CMP_W'(r_prev) < CMP_W'(LEVELS);
        row_in   = CMP_W'(i_row_level) < CMP_W'(LEVELS);
        col_in   = CMP_W'(i_col_level) < CMP_W'(LEVELS);
        lvl_a_hi = is_pixel ? LVL_BITS'(i_gray) : LVL_BITS'(i_row_level);
        lvl_a_lo = is_pixel ? LVL_BITS'(r_prev) : LVL_BITS'(i_col_level);
        addr_a   = ADDR_BITS'(lvl_a_hi) * ADDR_BITS'(LEVELS) + ADDR_BITS'(lvl_a_lo);
        addr_b   = ADDR_BITS'(LVL_BITS'(r_prev)) * ADDR_BITS'(LEVELS)
                 + ADDR_BITS'(LVL_BITS'(i_gray));
    end

    // Capture the item; prev level advances on every pixel
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_kind <= glcm_pkg::KIND_PIXEL;
            r_prev <= '0;
            r_ok   <= 1'b0;
            r_same <= 1'b0;
        end else if (i_cmd.load) begin
            r_kind <= i_kind;
            r_same <= (i_gray == r_prev);
            r_ok   <= is_pixel ? (!i_row_first && cur_in && prev_in) : (row_in && col_in);
            if (is_pixel) r_prev <= i_gray;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_addr_a <= addr_a;
            r_addr_b <= addr_b;
        end
    end

    always_comb begin
        sum_a = {1'b0, r_mem_q} + ((COUNT_BITS + 1)'(r_same ? 2 : 1));
        sum_b = {1'b0, r_mem_q} + (COUNT_BITS + 1)'(1);
        sum_t = {1'b0, r_total} + (COUNT_BITS + 1)'(2);
        sat_a = sum_a[COUNT_BITS] ? '1 : sum_a[COUNT_BITS-1:0];
        sat_b = sum_b[COUNT_BITS] ? '1 : sum_b[COUNT_BITS-1:0];
        sat_t = sum_t[COUNT_BITS] ? '1 : sum_t[COUNT_BITS-1:0];
    end

    // Memory port selection
    always_comb begin
        mem_we = i_cmd.sweep | i_cmd.wr_a | i_cmd.wr_b;
        mem_wa = r_sweep;
        mem_wd = '0;
        if (i_cmd.wr_a) begin
            mem_wa = r_addr_a;
            mem_wd = sat_a;
        end else if (i_cmd.wr_b) begin
            mem_wa = r_addr_b;
            mem_wd = sat_b;
        end
        mem_re = i_cmd.rd_a | i_cmd.rd_b;
        mem_ra = i_cmd.rd_b ? r_addr_b : r_addr_a;
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) mem[mem_wa] <= mem_wd;
        if (mem_re) r_mem_q <= mem[mem_ra];
    end

    // Sweep counter and pair total
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sweep <= '0;
            r_total <= '0;
        end else begin
            if (i_cmd.clr_start) begin
                r_sweep <= '0;
                r_total <= '0;
            end else if (i_cmd.sweep) begin
                r_sweep <= r_sweep + ADDR_BITS'(1);
            end
            if (i_cmd.tot_inc) r_total <= sat_t;
        end
    end

    // Fraction: restoring division of entry * 2^16 by total
    always_comb begin
        rem2     = {r_rem, 1'b0};
        rem_diff = rem2 - {1'b0, r_total};
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.take_entry) r_entry <= r_ok ? r_mem_q : '0;
        if (i_cmd.div_init) begin
            r_rem     <= r_entry;
            r_div_cnt <= '0;
            r_quo     <= ((r_total != '0) && (r_entry >= r_total)) ? glcm_pkg::FRAC_ONE : '0;
        end else if (i_cmd.div_step) begin
            r_div_cnt <= r_div_cnt + glcm_pkg::DIV_CNT_W'(1);
            if (rem2 >= {1'b0, r_total}) begin
                r_rem <= rem_diff[COUNT_BITS-1:0];
                r_quo <= {r_quo[glcm_pkg::FRAC_W-2:0], 1'b1};
            end else begin
                r_rem <= rem2[COUNT_BITS-1:0];
                r_quo <= {r_quo[glcm_pkg::FRAC_W-2:0], 1'b0};
            end
        end
    end

    // Output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_valid <= 1'b0;
        end else if (i_cmd.out_load) begin
            r_o_valid <= 1'b1;
        end else if (!i_stall) begin
            r_o_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            r_o_entry <= glcm_pkg::OUT_W'(r_entry);
            r_o_total <= glcm_pkg::OUT_W'(r_total);
            r_o_frac  <= r_quo;
        end
    end

    assign o_valid       = r_o_valid;
    assign o_entry_count = r_o_entry;
    assign o_total_pairs = r_o_total;
    assign o_fraction    = r_o_frac;

    always_comb begin
        o_stat.kind       = r_kind;
        o_stat.ok         = r_ok;
        o_stat.same       = r_same;
        o_stat.sweep_last = (r_sweep == ADDR_BITS'(DEPTH - 1));
        o_stat.div_short  = (r_total == '0) || (r_entry >= r_total);
        o_stat.div_last   = (r_div_cnt == glcm_pkg::DIV_CNT_W'(glcm_pkg::FRAC_BITS - 1));
        o_stat.out_free   = !r_o_valid || !i_stall;
    end

endmodule

// File: rtl/core/glcm_horizontal_builder.sv
// ----------------------------------------------------------------------------
// glcm_horizontal_builder
// Symmetric horizontal gray-level co-occurrence matrix builder.
// ----------------------------------------------------------------------------
// Feed pixels (kind pixel) in raster order with row_first set on the first
// pixel of each row; each later pixel adds one to entries [cur][prev] and
// [prev][cur] (two to the diagonal entry when the levels match) and two to
// the pair total, all counts saturating. A read item returns one entry, the
// total and the entry as a truncated Q1.16 fraction of the total; a clear
// item zeroes matrix and total but keeps the left neighbor. Items are taken
// one at a time through a single-port-read, single-port-write count memory:
// a pixel that pairs with nothing only dispatches, a diagonal pair makes one
// and an off-diagonal pair two read-modify-write passes on the memory; a
// read skips the divider when the total is zero or the entry reaches the
// total, otherwise it runs the 16-step bit-serial divider. After reset, and
// after each clear item, a clearing pass writes zero to all LEVELS*LEVELS
// entries, one per cycle, with stall held high. A finished read result
// waits in the output register while the next item is taken.
// ----------------------------------------------------------------------------
module glcm_horizontal_builder #(
    parameter int unsigned LEVELS     = glcm_pkg::LEVELS_DEF,
    parameter int unsigned COUNT_BITS = glcm_pkg::COUNT_BITS_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    // Item channel
    input  logic                        i_valid,
    output logic                        o_stall,
    input  logic [glcm_pkg::KIND_W-1:0] i_kind,
    input  logic [glcm_pkg::GRAY_W-1:0] i_gray,
    input  logic                        i_row_first,
    input  logic [glcm_pkg::GRAY_W-1:0] i_row_level,
    input  logic [glcm_pkg::GRAY_W-1:0] i_col_level,
    // Result channel
    output logic                        o_valid,
    input  logic                        i_stall,
    output logic [glcm_pkg::OUT_W-1:0]  o_entry_count,
    output logic [glcm_pkg::OUT_W-1:0]  o_total_pairs,
    output logic [glcm_pkg::FRAC_W-1:0] o_fraction
);

    glcm_pkg::t_cmd  cmd;
    glcm_pkg::t_stat stat;

    // Sequencer: decides what the datapath does each cycle
    glcm_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_stall (o_stall),
        .i_stat  (stat),
        .o_cmd   (cmd)
    );

    // Count memory, adders, divider and output register
    glcm_dpath #(
        .LEVELS     (LEVELS),
        .COUNT_BITS (COUNT_BITS)
    ) u_dpath (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (cmd),
        .o_stat        (stat),
        .i_kind        (i_kind),
        .i_gray        (i_gray),
        .i_row_first   (i_row_first),
        .i_row_level   (i_row_level),
        .i_col_level   (i_col_level),
        .o_valid       (o_valid),
        .i_stall       (i_stall),
        .o_entry_count (o_entry_count),
        .o_total_pairs (o_total_pairs),
        .o_fraction    (o_fraction)
    );

    // No transfer is taken while the clearing pass runs
    a_no_accept_in_sweep: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.sweep |-> o_stall)
        else $error("item accepted during clearing pass");

    // Never overwrite a result that is still waiting
    a_out_not_overwritten: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && i_stall) |-> !cmd.out_load)
        else $error("pending result overwritten");

    // Second entry update follows the first and only for an off-diagonal pair
    a_wr_b_after_wr_a: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.wr_b |-> ($past(cmd.wr_a) && !stat.same))
        else $error("second entry written out of order");

    // Fraction never exceeds one
    a_frac_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_fraction <= glcm_pkg::FRAC_ONE))
        else $error("fraction above one");

endmodule
